### design/mcbf_pkg.sv
// Package for the multi-channel byte FIFO table: command, status and
// back-end operation codes, and the entry type carried from front to back.
// Used by mcbf_front, mcbf_back and the top level; depends on nothing.
package mcbf_pkg;

   localparam logic [1:0] CMD_OPEN  = 2'd0;
   localparam logic [1:0] CMD_CLOSE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_WRITE = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_UNKNOWN = 3'd1;
   localparam logic [2:0] ST_NOSLOT  = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   // Work handed to the back end for one transfer.
   localparam logic [1:0] OP_NOP   = 2'd0; // result already decided by the front
   localparam logic [1:0] OP_CLEAR = 2'd1; // slot newly taken: clear its pointers
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_WRITE = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] status;
      logic [7:0] data;
   } entry_type;

endpackage

### design/mcbf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
module mcbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/mcbf_queue.sv
// Two-entry register queue that separates the front end from the back end.
// Standalone; carries an opaque vector of WIDTH bits.
module mcbf_queue #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_sel_ff, wr_sel_in;
   logic             rd_sel_ff, rd_sel_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_sel_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_sel_in = push ? ~wr_sel_ff : wr_sel_ff;
      rd_sel_in = pop ? ~rd_sel_ff : rd_sel_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_sel_ff <= 1'b0;
         rd_sel_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_sel_ff <= wr_sel_in;
         rd_sel_ff <= rd_sel_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_sel_ff] <= push_data;
      end
   end

endmodule

### design/mcbf_front.sv
// Front end: holds the slot table (valid, channel id, user count), looks up
// each request, settles open and close, and queues work for the back end.
// Depends on mcbf_pkg.
module mcbf_front #(
   parameter int NUM_CHANNELS = 8,
   parameter int SLOT_W       = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic [31:0]        req_pipe_id,
   input  logic [7:0]         req_data_byte,
   output logic               push_valid,
   input  logic               push_ready,
   output mcbf_pkg::entry_type push_entry,
   output logic [SLOT_W-1:0]  push_slot
);

   logic [NUM_CHANNELS-1:0] valid_ff, valid_in;
   logic [31:0]             key_ff   [NUM_CHANNELS];
   logic [7:0]              users_ff [NUM_CHANNELS];
   logic [7:0]              users_in;
   logic                    users_we;
   logic                    key_we;
   logic                    hit, free;
   logic [SLOT_W-1:0]       hit_slot, free_slot, tgt_slot;
   logic [7:0]              users_cur;
   logic                    accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;
   assign push_slot  = tgt_slot;

   // Lowest matching slot and lowest free slot.
   always_comb begin
      hit       = 1'b0;
      hit_slot  = '0;
      free      = 1'b0;
      free_slot = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (key_ff[i] == req_pipe_id)) begin
            hit      = 1'b1;
            hit_slot = SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            free      = 1'b1;
            free_slot = SLOT_W'(i);
         end
      end
   end

   assign users_cur = users_ff[hit_slot];

   always_comb begin
      valid_in          = valid_ff;
      users_in          = users_cur;
      users_we          = 1'b0;
      key_we            = 1'b0;
      tgt_slot          = hit_slot;
      push_entry.op     = mcbf_pkg::OP_NOP;
      push_entry.status = mcbf_pkg::ST_OK;
      push_entry.data   = req_data_byte;
      unique case (req_cmd)
         mcbf_pkg::CMD_OPEN: begin
            if (hit) begin
               users_we = 1'b1;
               users_in = (users_cur == 8'hFF) ? users_cur : users_cur + 8'd1;
            end else if (free) begin
               tgt_slot            = free_slot;
               valid_in[free_slot] = 1'b1;
               key_we              = 1'b1;
               users_we            = 1'b1;
               users_in            = 8'd1;
               push_entry.op       = mcbf_pkg::OP_CLEAR;
            end else begin
               push_entry.status = mcbf_pkg::ST_NOSLOT;
            end
         end
         mcbf_pkg::CMD_CLOSE: begin
            if (!hit) begin
               push_entry.status = mcbf_pkg::ST_UNKNOWN;
            end else begin
               users_we = 1'b1;
               users_in = (users_cur == 8'd0) ? 8'd0 : users_cur - 8'd1;
               if (users_in == 8'd0) begin
                  valid_in[hit_slot] = 1'b0;
               end
            end
         end
         mcbf_pkg::CMD_READ: begin
            if (!hit) begin
               push_entry.status = mcbf_pkg::ST_UNKNOWN;
            end else begin
               push_entry.op = mcbf_pkg::OP_READ;
            end
         end
         mcbf_pkg::CMD_WRITE: begin
            if (!hit) begin
               push_entry.status = mcbf_pkg::ST_UNKNOWN;
            end else begin
               push_entry.op = mcbf_pkg::OP_WRITE;
            end
         end
         default: begin
            push_entry.status = mcbf_pkg::ST_UNKNOWN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            users_ff[i] <= 8'd0;
         end
      end else if (accept) begin
         valid_ff <= valid_in;
         if (users_we) begin
            users_ff[tgt_slot] <= users_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && key_we) begin
         key_ff[tgt_slot] <= req_pipe_id;
      end
   end

endmodule

### design/mcbf_back.sv
// Back end: per-slot read and write pointers and fill levels, the shared
// byte memory, and the result register. Depends on mcbf_pkg and mcbf_ram.
module mcbf_back #(
   parameter int NUM_CHANNELS = 8,
   parameter int DEPTH        = 256,
   parameter int SLOT_W       = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               entry_valid,
   output logic               entry_pop,
   input  mcbf_pkg::entry_type entry,
   input  logic [SLOT_W-1:0]  entry_slot,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_read_byte
);

   localparam int PTR_W     = $clog2(DEPTH);
   localparam int FILL_W    = $clog2(DEPTH + 1);
   localparam int ADDR_W    = SLOT_W + PTR_W;
   localparam int MEM_DEPTH = 2 ** ADDR_W;

   localparam logic S_EXEC = 1'b0;
   localparam logic S_READ = 1'b1;

   logic              state_ff, state_in;
   logic [PTR_W-1:0]  rd_ptr_ff [NUM_CHANNELS];
   logic [PTR_W-1:0]  wr_ptr_ff [NUM_CHANNELS];
   logic [FILL_W-1:0] fill_ff   [NUM_CHANNELS];
   logic [PTR_W-1:0]  rp, wp, rp_in, wp_in;
   logic [FILL_W-1:0] fill, fill_in;
   logic              clr, rd_adv, wr_adv;
   logic              out_free, take;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_read_byte_ff, rsp_read_byte_in;
   logic              mem_we, mem_re;
   logic [7:0]        mem_rdata;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign take      = (state_ff == S_EXEC) && entry_valid && out_free;
   assign entry_pop = take;

   assign rp    = rd_ptr_ff[entry_slot];
   assign wp    = wr_ptr_ff[entry_slot];
   assign fill  = fill_ff[entry_slot];
   assign rp_in = (rp == PTR_W'(DEPTH - 1)) ? '0 : rp + PTR_W'(1);
   assign wp_in = (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + PTR_W'(1);

   always_comb begin
      state_in         = state_ff;
      clr              = 1'b0;
      rd_adv           = 1'b0;
      wr_adv           = 1'b0;
      mem_we           = 1'b0;
      mem_re           = 1'b0;
      fill_in          = fill;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_read_byte_in = rsp_read_byte_ff;
      unique case (state_ff)
         S_EXEC: begin
            if (take) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = entry.status;
               rsp_read_byte_in = 8'd0;
               unique case (entry.op)
                  mcbf_pkg::OP_NOP: begin
                  end
                  mcbf_pkg::OP_CLEAR: begin
                     clr = 1'b1;
                  end
                  mcbf_pkg::OP_READ: begin
                     if (fill == '0) begin
                        rsp_status_in = mcbf_pkg::ST_EMPTY;
                     end else begin
                        // The byte arrives from the memory in the next cycle.
                        rsp_valid_in = 1'b0;
                        mem_re       = 1'b1;
                        rd_adv       = 1'b1;
                        fill_in      = fill - FILL_W'(1);
                        state_in     = S_READ;
                     end
                  end
                  mcbf_pkg::OP_WRITE: begin
                     if (fill == FILL_W'(DEPTH)) begin
                        rsp_status_in = mcbf_pkg::ST_FULL;
                     end else begin
                        mem_we  = 1'b1;
                        wr_adv  = 1'b1;
                        fill_in = fill + FILL_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in     = 1'b1;
            rsp_status_in    = mcbf_pkg::ST_OK;
            rsp_read_byte_in = mem_rdata;
            state_in         = S_EXEC;
         end
         default: begin
            state_in = S_EXEC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_EXEC;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
            fill_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clr) begin
            rd_ptr_ff[entry_slot] <= '0;
            wr_ptr_ff[entry_slot] <= '0;
            fill_ff[entry_slot]   <= '0;
         end
         if (rd_adv) begin
            rd_ptr_ff[entry_slot] <= rp_in;
            fill_ff[entry_slot]   <= fill_in;
         end
         if (wr_adv) begin
            wr_ptr_ff[entry_slot] <= wp_in;
            fill_ff[entry_slot]   <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff    <= rsp_status_in;
      rsp_read_byte_ff <= rsp_read_byte_in;
   end

   mcbf_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr ({entry_slot, wp}),
      .wr_data (entry.data),
      .rd_en   (mem_re),
      .rd_addr ({entry_slot, rp}),
      .rd_data (mem_rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_byte = rsp_read_byte_ff;

endmodule

### design/multi_channel_byte_fifo_table_unit.sv
// Top level of the multi-channel byte FIFO table.
// Depends on mcbf_pkg, mcbf_front, mcbf_queue and mcbf_back.
//
// Usage: each request transfer on the req_ channel carries a command
// (open, close, read byte, write byte), a 32-bit channel id and a data byte.
// Every request yields exactly one response transfer on the rsp_ channel with
// a status code and, for a successful read, the popped byte (zero otherwise).
// Responses come back in request order.
//
// The front end looks the id up in the slot table in the cycle of the
// transfer and settles opens and closes there; the back end owns the byte
// memory and per-channel pointers. A two-entry queue lets the two run apart.
// A response passes through the queue and the response register after its
// request transfer; a read that returns a byte also passes through the
// registered memory read. Requests are taken one per cycle while the queue
// has room; a read that returns a byte holds the back end until it is out.
//
// Reset frees all slots and clears all pointers and fill levels; the byte
// memory is not cleared and needs no clearing pass. While the receiver holds
// rsp_ready low the response stays in the output register, the back end stops
// and the queue fills; req_ready then drops once the queue is full.
module multi_channel_byte_fifo_table_unit #(
   parameter int NUM_CHANNELS = 8,
   parameter int DEPTH        = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_pipe_id,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_read_byte
);

   localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int Q_W    = $bits(mcbf_pkg::entry_type) + SLOT_W;

   mcbf_pkg::entry_type push_entry, pop_entry;
   logic [SLOT_W-1:0]   push_slot, pop_slot;
   logic                q_push_valid, q_push_ready;
   logic                q_pop_valid, q_pop;

   mcbf_front #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .SLOT_W       (SLOT_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_pipe_id   (req_pipe_id),
      .req_data_byte (req_data_byte),
      .push_valid    (q_push_valid),
      .push_ready    (q_push_ready),
      .push_entry    (push_entry),
      .push_slot     (push_slot)
   );

   // Queue payload: the entry with the slot index below it.
   mcbf_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  ({push_entry, push_slot}),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop),
      .pop_data   ({pop_entry, pop_slot})
   );

   mcbf_back #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .DEPTH        (DEPTH),
      .SLOT_W       (SLOT_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .entry_valid   (q_pop_valid),
      .entry_pop     (q_pop),
      .entry         (pop_entry),
      .entry_slot    (pop_slot),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_read_byte (rsp_read_byte)
   );

   // The back end only takes work the queue actually holds.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_pop_valid)
      else $error("back end popped an empty queue");

   // Reads and writes reach the back end only for a known id, with no verdict yet.
   assert property (@(posedge clock) disable iff (reset)
      q_pop_valid && (pop_entry.op == mcbf_pkg::OP_READ ||
                      pop_entry.op == mcbf_pkg::OP_WRITE)
      |-> pop_entry.status == mcbf_pkg::ST_OK)
      else $error("queued read or write already carries an error status");

   // No response is pending in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule
